### src/pbc_pkg.sv
// ----------------------------------------------------------------------------
// pbc_pkg: shared types for the position bias corrector
// Holds the controller state encoding and the command bundle that the
// controller sends to the datapath.
// ----------------------------------------------------------------------------
package pbc_pkg;

    // Number of position axes and the width of an axis index.
    localparam int NUM_AXES  = 3;
    localparam int AXIS_W    = 2;
    localparam logic [AXIS_W-1:0] AXIS_FIRST = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_LAST  = 2'd2;

    // Controller states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ERR    = 7'b0000010,
        S_ACC    = 7'b0000100,
        S_SUM    = 7'b0001000,
        S_DSTART = 7'b0010000,
        S_DWAIT  = 7'b0100000,
        S_FUSE   = 7'b1000000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              capture;    // take the input beat
        logic              err_step;   // latch inertial, form per-axis error
        logic              acc_step;   // update count, accumulators, marker
        logic              sum_step;   // form marker + inertial per axis
        logic              div_start;  // start the divider on the chosen axis
        logic              fuse;       // write the corrected value of the axis
        logic              out_load;   // move the results to the output register
        logic [AXIS_W-1:0] axis;       // axis being worked on
    } t_dp_cmd;

endpackage

### src/pbc_divider.sv
// ----------------------------------------------------------------------------
// pbc_divider: radix-2 restoring unsigned divider
// Produces one quotient bit per cycle. The quotient is valid in the cycle
// in which o_done is high and stays until the next start.
// ----------------------------------------------------------------------------
module pbc_divider #(
    parameter int DIVIDEND_W = 57,
    parameter int DIVISOR_W  = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);
    localparam logic [CNT_W-1:0] STEPS    = CNT_W'(DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0]    n_shift;
    logic [DIVISOR_W:0]    n_diff;
    logic                  n_ge;

    // Shift in the next dividend bit and trial-subtract the divisor.
    always_comb begin
        n_shift = {r_rem, r_quo[DIVIDEND_W-1]};
        n_diff  = n_shift - {1'b0, r_div};
        n_ge    = (n_shift >= {1'b0, r_div});
    end

    // Control: busy flag, step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - LAST_CNT;
                if (r_cnt == LAST_CNT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[DIVISOR_W-1:0] : n_shift[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], n_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### src/pbc_ctrl.sv
// ----------------------------------------------------------------------------
// pbc_ctrl: controller for the position bias corrector
// Steps one item through the state update and the three per-axis
// divisions, and owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module pbc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  logic             i_div_done,
    output pbc_pkg::t_dp_cmd o_cmd
);
    import pbc_pkg::*;

    t_state            r_state, n_state;
    logic [AXIS_W-1:0] r_axis, n_axis;
    logic              r_out_valid, n_out_valid;
    logic              out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !r_out_valid || i_out_ready;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                n_axis  = AXIS_FIRST;
                n_state = S_DSTART;
            end
            S_DSTART: begin
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_div_done) begin
                    n_state = S_FUSE;
                end
            end
            S_FUSE: begin
                if (r_axis != AXIS_LAST) begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_DSTART;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath. The last axis holds in S_FUSE until the
    // output register is free; rewriting the same result meanwhile is harmless.
    always_comb begin
        o_cmd           = '0;
        o_cmd.axis      = r_axis;
        o_cmd.capture   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.err_step  = (r_state == S_ERR);
        o_cmd.acc_step  = (r_state == S_ACC);
        o_cmd.sum_step  = (r_state == S_SUM);
        o_cmd.div_start = (r_state == S_DSTART);
        o_cmd.fuse      = (r_state == S_FUSE);
        o_cmd.out_load  = (r_state == S_FUSE) && (r_axis == AXIS_LAST) && out_free;
    end

    // Output valid: set on load, cleared once the beat is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= AXIS_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### src/pbc_datapath.sv
// ----------------------------------------------------------------------------
// pbc_datapath: state and arithmetic of the position bias corrector
// Holds the latched positions, error accumulators and sample count, and
// forms the corrected position one axis at a time through a shared divider.
// ----------------------------------------------------------------------------
module pbc_datapath #(
    parameter int POS_W = 32,
    parameter int CNT_W = 24,
    parameter int ACC_W = 57
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pbc_pkg::t_dp_cmd        i_cmd,
    output logic                    o_div_done,
    input  logic                    i_imu_valid,
    input  logic signed [POS_W-1:0] i_imu_pos [pbc_pkg::NUM_AXES],
    input  logic                    i_marker_valid,
    input  logic signed [POS_W-1:0] i_marker_pos [pbc_pkg::NUM_AXES],
    output logic                    o_updated,
    output logic signed [POS_W-1:0] o_fused [pbc_pkg::NUM_AXES]
);
    import pbc_pkg::*;

    localparam int ERR_W = POS_W + 2;
    localparam int DIF_W = ACC_W + 2;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // Captured input beat.
    logic                    r_in_imu_v;
    logic                    r_in_mk_v;
    logic signed [POS_W-1:0] r_in_imu [NUM_AXES];
    logic signed [POS_W-1:0] r_in_mk  [NUM_AXES];

    // Fusion state.
    logic signed [POS_W-1:0] r_inertial [NUM_AXES];
    logic signed [POS_W-1:0] r_marker   [NUM_AXES];
    logic signed [ACC_W-1:0] r_acc      [NUM_AXES];
    logic [CNT_W-1:0]        r_count;

    // Working registers.
    logic signed [ERR_W-1:0] r_err  [NUM_AXES];
    logic signed [POS_W:0]   r_psum [NUM_AXES];
    logic signed [POS_W-1:0] r_res  [NUM_AXES];
    logic                    r_out_upd;
    logic signed [POS_W-1:0] r_out_fused [NUM_AXES];

    logic signed [POS_W-1:0] n_inertial [NUM_AXES];
    logic signed [ERR_W-1:0] n_err      [NUM_AXES];
    logic signed [ACC_W-1:0] n_acc      [NUM_AXES];
    logic signed [ACC_W:0]   acc_sum    [NUM_AXES];
    logic                    room;

    logic signed [ACC_W-1:0] sel_acc;
    logic                    sel_neg;
    logic [ACC_W-1:0]        sel_mag;
    logic                    div_done;
    logic [ACC_W-1:0]        div_quo;
    logic signed [ACC_W:0]   corr;
    logic signed [DIF_W-1:0] diff;
    logic [DIF_W-POS_W:0]    diff_hi;
    logic signed [POS_W-1:0] n_res;

    // Count freezes at its all-ones limit.
    assign room = (r_count != {CNT_W{1'b1}});

    // Error per axis against the freshly latched inertial position, and the
    // saturating accumulator update.
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n_inertial[a] = r_in_imu_v ? r_in_imu[a] : r_inertial[a];
            n_err[a]      = ERR_W'(r_in_mk[a])
                          - (ERR_W'(r_marker[a]) + ERR_W'(n_inertial[a]));
            acc_sum[a]    = (ACC_W+1)'(r_acc[a]) + (ACC_W+1)'(r_err[a]);
            if (acc_sum[a][ACC_W] != acc_sum[a][ACC_W-1]) begin
                n_acc[a] = acc_sum[a][ACC_W] ? ACC_MIN : ACC_MAX;
            end else begin
                n_acc[a] = acc_sum[a][ACC_W-1:0];
            end
        end
    end

    // Input capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_imu_v <= i_imu_valid;
            r_in_mk_v  <= i_marker_valid;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_in_imu[a] <= i_imu_pos[a];
                r_in_mk[a]  <= i_marker_pos[a];
            end
        end
    end

    // Fusion state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_inertial[a] <= '0;
                r_marker[a]   <= '0;
                r_acc[a]      <= '0;
            end
        end else begin
            if (i_cmd.err_step) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_inertial[a] <= n_inertial[a];
                end
            end
            if (i_cmd.acc_step && r_in_mk_v) begin
                if (room) begin
                    r_count <= r_count + CNT_ONE;
                end
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (room) begin
                        r_acc[a] <= n_acc[a];
                    end
                    r_marker[a] <= r_in_mk[a];
                end
            end
        end
    end

    // Error and position-sum working registers.
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < NUM_AXES; a++) begin
            if (i_cmd.err_step) begin
                r_err[a] <= n_err[a];
            end
            if (i_cmd.sum_step) begin
                r_psum[a] <= (POS_W+1)'(r_marker[a]) + (POS_W+1)'(r_inertial[a]);
            end
        end
    end

    // Divider operand: magnitude of the selected accumulator.
    always_comb begin
        sel_acc = r_acc[i_cmd.axis];
        sel_neg = sel_acc[ACC_W-1];
        sel_mag = sel_neg ? ACC_W'(-sel_acc) : ACC_W'(sel_acc);
    end

    pbc_divider #(
        .DIVIDEND_W (ACC_W),
        .DIVISOR_W  (CNT_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (sel_mag),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Corrected position: restore the sign, subtract and saturate.
    always_comb begin
        if (r_count == '0) begin
            corr = '0;
        end else if (sel_neg) begin
            corr = -$signed({1'b0, div_quo});
        end else begin
            corr = $signed({1'b0, div_quo});
        end
        diff    = DIF_W'(r_psum[i_cmd.axis]) - DIF_W'(corr);
        diff_hi = diff[DIF_W-1:POS_W-1];
        if (!(&diff_hi) && (|diff_hi)) begin
            n_res = diff[DIF_W-1] ? POS_MIN : POS_MAX;
        end else begin
            n_res = diff[POS_W-1:0];
        end
    end

    // Per-axis results and the output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fuse) begin
            r_res[i_cmd.axis] <= n_res;
        end
        if (i_cmd.out_load) begin
            r_out_upd <= r_in_imu_v || r_in_mk_v;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_out_fused[a] <= (a == int'(i_cmd.axis)) ? n_res : r_res[a];
            end
        end
    end

    assign o_div_done = div_done;
    assign o_updated  = r_out_upd;
    assign o_fused    = r_out_fused;

endmodule

### src/position_bias_corrector.sv
// ----------------------------------------------------------------------------
// position_bias_corrector: inertial/marker position fusion with drift removal
//
//   Channel   Handshake                  Beat contents
//   input     i_in_valid / o_in_ready    i_imu_valid, i_imu_x/y/z,
//                                        i_marker_valid, i_marker_x/y/z
//   output    o_out_valid / i_out_ready  o_updated, o_fused_x/y/z
//
// Each item runs three per-axis divisions in turn on one radix-2 divider
// that produces one quotient bit per cycle.
// Reset (i_rst_n low, synchronous) clears the latched positions, accumulators
// and the sample count, and empties the output register.
// A finished result waits in the output register while the next item is
// accepted; if it is still not taken when the next result is ready, the
// block holds that result and accepts no further item until it drains.
// ----------------------------------------------------------------------------
module position_bias_corrector #(
    parameter int POS_WIDTH   = 32,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_imu_valid,
    input  logic signed [POS_WIDTH-1:0] i_imu_x,
    input  logic signed [POS_WIDTH-1:0] i_imu_y,
    input  logic signed [POS_WIDTH-1:0] i_imu_z,
    input  logic                        i_marker_valid,
    input  logic signed [POS_WIDTH-1:0] i_marker_x,
    input  logic signed [POS_WIDTH-1:0] i_marker_y,
    input  logic signed [POS_WIDTH-1:0] i_marker_z,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_updated,
    output logic signed [POS_WIDTH-1:0] o_fused_x,
    output logic signed [POS_WIDTH-1:0] o_fused_y,
    output logic signed [POS_WIDTH-1:0] o_fused_z
);
    import pbc_pkg::*;

    // Accumulator width, capped so that it stays within 62 bits.
    localparam int ACC_WIDTH = (POS_WIDTH + COUNT_WIDTH + 1 > 62) ?
                               62 : (POS_WIDTH + COUNT_WIDTH + 1);

    t_dp_cmd                 cmd;
    logic                    div_done;
    logic signed [POS_WIDTH-1:0] imu_pos    [NUM_AXES];
    logic signed [POS_WIDTH-1:0] marker_pos [NUM_AXES];
    logic signed [POS_WIDTH-1:0] fused      [NUM_AXES];

    // Gather the per-axis ports.
    assign imu_pos[0]    = i_imu_x;
    assign imu_pos[1]    = i_imu_y;
    assign imu_pos[2]    = i_imu_z;
    assign marker_pos[0] = i_marker_x;
    assign marker_pos[1] = i_marker_y;
    assign marker_pos[2] = i_marker_z;

    pbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_div_done  (div_done),
        .o_cmd       (cmd)
    );

    pbc_datapath #(
        .POS_W (POS_WIDTH),
        .CNT_W (COUNT_WIDTH),
        .ACC_W (ACC_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_div_done     (div_done),
        .i_imu_valid    (i_imu_valid),
        .i_imu_pos      (imu_pos),
        .i_marker_valid (i_marker_valid),
        .i_marker_pos   (marker_pos),
        .o_updated      (o_updated),
        .o_fused        (fused)
    );

    assign o_fused_x = fused[0];
    assign o_fused_y = fused[1];
    assign o_fused_z = fused[2];

endmodule
